FILE: sv/spd_pkg.sv
// Shared types, constants and register codes for the sensor packet deframer.
package spd_pkg;

  localparam int PACKET_BYTES = 17;

  localparam logic [7:0]  SEP_FIRST_RST   = 8'd170;
  localparam logic [7:0]  SEP_SECOND_RST  = 8'd85;
  localparam logic [7:0]  DECIMATION_RST  = 8'd10;
  localparam logic [15:0] FULL_SCALE_RST  = 16'hFFFF;
  localparam logic [8:0]  INVERT_MASK_RST = 9'd0;

  localparam logic [3:0] CHAN_NONE    = 4'hF;
  localparam logic [3:0] CHAN_DIGITAL = 4'd8;
  localparam logic [3:0] CHAN_COUNT   = 4'd9;

  typedef enum logic [2:0] {
    REG_SEP_FIRST   = 3'd0,
    REG_SEP_SECOND  = 3'd1,
    REG_DECIMATION  = 3'd2,
    REG_FULL_SCALE  = 3'd3,
    REG_INVERT_MASK = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    KIND_STATUS = 2'd0,
    KIND_CLOCK  = 2'd1,
    KIND_CHAN   = 2'd2
  } kind_t;

  typedef struct packed {
    logic [7:0]  sep_first;
    logic [7:0]  sep_second;
    logic [7:0]  decimation;
    logic [15:0] full_scale;
    logic [8:0]  invert_mask;
  } cfg_t;

  typedef struct packed {
    kind_t       kind;
    logic [3:0]  chan_index;
    logic [15:0] value;
    logic        last;
  } result_t;

  typedef struct packed {
    logic       busy;
    logic       done;
    logic [7:0] rem;
  } mod_res_t;

  function automatic logic [7:0] dec_eff(input logic [7:0] d);
    dec_eff = (d == 8'd0) ? 8'd1 : d;
  endfunction

endpackage

FILE: sv/spd_regs.sv
// APB configuration registers of the sensor packet deframer.
module spd_regs (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output spd_pkg::cfg_t     cfg,
  output logic              dec_wr
);
  import spd_pkg::*;

  logic     wr;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[4:2]);
  assign dec_wr = wr && (idx == REG_DECIMATION);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sep_first   <= SEP_FIRST_RST;
      cfg.sep_second  <= SEP_SECOND_RST;
      cfg.decimation  <= DECIMATION_RST;
      cfg.full_scale  <= FULL_SCALE_RST;
      cfg.invert_mask <= INVERT_MASK_RST;
    end else if (wr) begin
      unique case (idx)
        REG_SEP_FIRST:   cfg.sep_first   <= pwdata[7:0];
        REG_SEP_SECOND:  cfg.sep_second  <= pwdata[7:0];
        REG_DECIMATION:  cfg.decimation  <= pwdata[7:0];
        REG_FULL_SCALE:  cfg.full_scale  <= pwdata[15:0];
        REG_INVERT_MASK: cfg.invert_mask <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SEP_FIRST:   prdata = {24'd0, cfg.sep_first};
      REG_SEP_SECOND:  prdata = {24'd0, cfg.sep_second};
      REG_DECIMATION:  prdata = {24'd0, cfg.decimation};
      REG_FULL_SCALE:  prdata = {16'd0, cfg.full_scale};
      REG_INVERT_MASK: prdata = {23'd0, cfg.invert_mask};
      default:         prdata = 32'd0;
    endcase
  end

endmodule

FILE: sv/spd_mod_unit.sv
// Bit-serial remainder of the packet skip count after a decimation change.
module spd_mod_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [7:0]        dividend,
  input  logic [7:0]        decimation,
  output spd_pkg::mod_res_t res
);
  import spd_pkg::*;

  logic       running;
  logic       done;
  logic [2:0] cnt;
  logic [7:0] dvd;
  logic [7:0] rem;
  logic [7:0] divisor;
  logic [8:0] shifted;

  assign divisor = dec_eff(decimation);
  assign shifted = {rem, dvd[7]};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= 3'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= 3'd7;
      end else if (running) begin
        if (cnt == 3'd0) begin
          running <= 1'b0;
          done    <= 1'b1;
        end else begin
          cnt <= cnt - 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      rem <= 8'd0;
    end else if (running) begin
      dvd <= {dvd[6:0], 1'b0};
      if (shifted >= {1'b0, divisor}) begin
        rem <= 8'(shifted - {1'b0, divisor});
      end else begin
        rem <= shifted[7:0];
      end
    end
  end

  assign res.busy = start || running || done;
  assign res.done = done;
  assign res.rem  = rem;

endmodule

FILE: sv/spd_core.sv
// Per-word deframing state and result formation.
module spd_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               fire,
  input  logic [7:0]         byte_in,
  input  spd_pkg::cfg_t      cfg,
  input  spd_pkg::mod_res_t  mod,
  output logic [7:0]         packet_skip,
  output logic [1:0]         push_n,
  output spd_pkg::result_t   res0,
  output spd_pkg::result_t   res1
);
  import spd_pkg::*;

  logic       synced, synced_next;
  logic       sep_select, sep_select_next;
  logic [4:0] byte_pos, byte_pos_next;
  logic [3:0] chan_pos, chan_pos_next;
  logic       odd_phase, odd_phase_next;
  logic [7:0] high_byte, high_byte_next;
  logic       clock_active, clock_active_next;
  logic       clock_low_next, clock_low_next_next;
  logic [7:0] packet_skip_next;
  logic [7:0] skip_mod, skip_mod_next;

  logic [7:0]  expected;
  logic [7:0]  dec;
  logic [8:0]  mod_inc;
  logic [15:0] sample;
  logic [15:0] chan_val;
  logic        store;
  logic        inv;
  result_t     clk_res;
  result_t     chan_res;

  assign expected = sep_select ? cfg.sep_second : cfg.sep_first;
  assign dec      = dec_eff(cfg.decimation);
  assign mod_inc  = {1'b0, skip_mod} + 9'd1;

  always_comb begin
    synced_next         = synced;
    sep_select_next     = sep_select;
    byte_pos_next       = byte_pos;
    chan_pos_next       = chan_pos;
    odd_phase_next      = odd_phase;
    high_byte_next      = high_byte;
    clock_active_next   = clock_active;
    clock_low_next_next = clock_low_next;
    packet_skip_next    = packet_skip;
    skip_mod_next       = skip_mod;
    sample              = 16'd0;
    store               = 1'b0;
    inv                 = 1'b0;
    chan_val            = 16'd0;
    push_n              = 2'd0;
    clk_res             = '{kind: KIND_CLOCK, chan_index: 4'd0, value: 16'd0, last: 1'b0};
    chan_res            = '{kind: KIND_CHAN, chan_index: 4'd0, value: 16'd0, last: 1'b1};
    res0                = '{kind: KIND_STATUS, chan_index: 4'd0, value: 16'd0, last: 1'b1};
    res1                = chan_res;

    if (!synced || (byte_pos >= 5'(PACKET_BYTES))) begin
      if (byte_in == expected) begin
        sep_select_next     = ~sep_select;
        byte_pos_next       = 5'd0;
        chan_pos_next       = CHAN_NONE;
        odd_phase_next      = 1'b0;
        high_byte_next      = 8'd0;
        clock_active_next   = 1'b1;
        clock_low_next_next = 1'b0;
        if (!synced) begin
          synced_next      = 1'b1;
          packet_skip_next = 8'd0;
          skip_mod_next    = 8'd0;
          res0.value       = cfg.full_scale;
          push_n           = 2'd1;
        end else begin
          packet_skip_next = packet_skip + 8'd1;
          if (packet_skip == 8'hFF || mod_inc == {1'b0, dec}) begin
            skip_mod_next = 8'd0;
          end else begin
            skip_mod_next = mod_inc[7:0];
          end
        end
      end else if (synced) begin
        synced_next = 1'b0;
        push_n      = 2'd1;
      end
    end else begin
      byte_pos_next = byte_pos + 5'd1;
      if (skip_mod == 8'd0) begin
        if (odd_phase) begin
          odd_phase_next = 1'b0;
          sample         = {high_byte, byte_in};
          store          = 1'b1;
        end else begin
          high_byte_next = byte_in;
          odd_phase_next = 1'b1;
          chan_pos_next  = chan_pos + 4'd1;
          if (chan_pos_next == CHAN_DIGITAL) begin
            sample = {byte_in, 8'd0};
            store  = 1'b1;
          end
        end

        if (clock_active) begin
          if (clock_low_next) begin
            clock_active_next   = 1'b0;
            clock_low_next_next = 1'b0;
          end else begin
            clock_low_next_next = 1'b1;
            clk_res.value       = cfg.full_scale;
          end
        end

        if (chan_pos_next < CHAN_COUNT) begin
          inv = cfg.invert_mask[chan_pos_next];
        end
        chan_val = sample;
        if (inv) begin
          chan_val = (sample > cfg.full_scale) ? 16'd0 : (cfg.full_scale - sample);
        end
        chan_res.chan_index = chan_pos_next;
        chan_res.value      = chan_val;

        if (store) begin
          odd_phase_next = 1'b0;
          high_byte_next = 8'd0;
        end

        packet_skip_next = 8'd0;
        skip_mod_next    = 8'd0;

        if (clock_active && store) begin
          res0   = clk_res;
          res1   = chan_res;
          push_n = 2'd2;
        end else if (clock_active) begin
          res0      = clk_res;
          res0.last = 1'b1;
          push_n    = 2'd1;
        end else if (store) begin
          res0   = chan_res;
          push_n = 2'd1;
        end
      end
    end

    if (!fire) begin
      push_n = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      synced         <= 1'b0;
      sep_select     <= 1'b0;
      byte_pos       <= 5'd0;
      chan_pos       <= CHAN_NONE;
      odd_phase      <= 1'b0;
      high_byte      <= 8'd0;
      clock_active   <= 1'b1;
      clock_low_next <= 1'b0;
      packet_skip    <= 8'd0;
      skip_mod       <= 8'd0;
    end else if (fire) begin
      synced         <= synced_next;
      sep_select     <= sep_select_next;
      byte_pos       <= byte_pos_next;
      chan_pos       <= chan_pos_next;
      odd_phase      <= odd_phase_next;
      high_byte      <= high_byte_next;
      clock_active   <= clock_active_next;
      clock_low_next <= clock_low_next_next;
      packet_skip    <= packet_skip_next;
      skip_mod       <= skip_mod_next;
    end else if (mod.done) begin
      skip_mod <= mod.rem;
    end
  end

endmodule

FILE: sv/spd_result_fifo.sv
// Four-entry result queue: push up to two words, pop one word per cycle while m_tready is high.
module spd_result_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic [1:0]        push_n,
  input  spd_pkg::result_t  res0,
  input  spd_pkg::result_t  res1,
  output logic              room2,
  output logic              m_tvalid,
  input  logic              m_tready,
  output spd_pkg::result_t  head
);
  import spd_pkg::*;

  result_t    q [4];
  logic [1:0] rd_ptr;
  logic [1:0] wr_ptr;
  logic [2:0] count;
  logic       pop;

  assign m_tvalid = (count != 3'd0);
  assign pop      = m_tvalid && m_tready;
  assign room2    = (count <= 3'd2);
  assign head     = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 2'd0;
      wr_ptr <= 2'd0;
      count  <= 3'd0;
    end else begin
      if (pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      wr_ptr <= wr_ptr + push_n;
      count  <= count + {1'b0, push_n} - {2'd0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      q[wr_ptr] <= res0;
    end
    if (push_n == 2'd2) begin
      q[wr_ptr + 2'd1] <= res1;
    end
  end

endmodule

FILE: sv/sensor_packet_deframer.sv
// Top level of the sensor packet deframer: input register, core, result queue, registers.
// Path: an accepted word is held in the input register, decoded by the core when it fires,
// and its results are registered into the result queue before they are offered.
// Throughput: one input word per cycle while the queue has room for two results and the remainder unit is idle.
// A write to the decimation register stalls input while the 8-step remainder unit is busy.
// Reset: synchronous, active high; clears sync state, queue and registers to defaults.
module sensor_packet_deframer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] byte_in
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [3:0] chan_index, [19:4] value, [23:20] zero
  output logic [1:0]  m_tuser,   // [1:0] kind
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import spd_pkg::*;

  cfg_t       cfg;
  logic       dec_wr;
  mod_res_t   mod;
  logic       in_valid;
  logic [7:0] in_byte;
  logic       fire;
  logic       room2;
  logic [7:0] packet_skip;
  logic [1:0] push_n;
  result_t    res0;
  result_t    res1;
  result_t    head;

  assign fire     = in_valid && room2 && !mod.busy;
  assign s_tready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
    end
  end

  spd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .dec_wr  (dec_wr)
  );

  spd_mod_unit u_mod (
    .clk        (clk),
    .rst        (rst),
    .start      (dec_wr),
    .dividend   (packet_skip),
    .decimation (cfg.decimation),
    .res        (mod)
  );

  spd_core u_core (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .byte_in     (in_byte),
    .cfg         (cfg),
    .mod         (mod),
    .packet_skip (packet_skip),
    .push_n      (push_n),
    .res0        (res0),
    .res1        (res1)
  );

  spd_result_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push_n   (push_n),
    .res0     (res0),
    .res1     (res1),
    .room2    (room2),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .head     (head)
  );

  assign m_tdata = {4'd0, head.value, head.chan_index};
  assign m_tuser = head.kind;
  assign m_tlast = head.last;

endmodule
